// ===== design/bctd_pkg.sv =====
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants of the block cache transpose directory.
// ----------------------------------------------------------------------------
package bctd_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned BSIZE_W  = 17;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 17'd64;
  localparam logic [BSIZE_W-1:0] BSIZE_MIN   = 17'd9;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ALIGN,
    ST_CMP,
    ST_ENC,
    ST_READ,
    ST_WRITE,
    ST_SWAP,
    ST_CANCEL,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic align;
    logic compare;
    logic encode;
    logic read;
    logic write;
    logic swap;
    logic cancel;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cancel;
    logic div_last;
    logic swap_needed;
    logic out_busy;
  } dp_status_t;

endpackage

// ===== design/bctd_if.sv =====
// ----------------------------------------------------------------------------
// bctd_if
// Valid/ready channel interfaces for lookup requests and results.
// ----------------------------------------------------------------------------
interface bctd_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] byte_address;

  modport source (output valid, output mode, output byte_address, input ready);
  modport sink (input valid, input mode, input byte_address, output ready);
endinterface

interface bctd_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [7:0]  slot;
  logic [63:0] block_address;
  logic        evicted_valid;
  logic [63:0] evicted_address;

  modport source (output valid, output hit, output slot, output block_address,
                  output evicted_valid, output evicted_address, input ready);
  modport sink (input valid, input hit, input slot, input block_address,
                input evicted_valid, input evicted_address, output ready);
endinterface

// ===== design/block_cache_transpose_directory.sv =====
// ----------------------------------------------------------------------------
// block_cache_transpose_directory
// Directory and transpose replacement engine of a block read cache.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req      in   mode, byte_address
// rsp      out  hit, slot, block_address, evicted_valid, evicted_address
// cfg      in   cfg_we, cfg_data (block size)
//
// A lookup runs the 64-step remainder of the address by the block size, then
// matches and updates; a hit away from the top slot also swaps two slots.
// One transaction is in flight at a time; a finished result sits in the
// output register, and the next request is taken while it waits.
// Reset clears the directory at once; so does a new block size >= BSIZE_MIN.
// ----------------------------------------------------------------------------
module block_cache_transpose_directory #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  bctd_req_if.sink    req,
  bctd_rsp_if.source  rsp
);

  bctd_pkg::dp_cmd_t    cmd;
  bctd_pkg::dp_status_t stat;
  logic                 in_ready;

  assign req.ready = in_ready;

  bctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bctd_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .req_mode         (req.mode),
    .req_byte_address (req.byte_address),
    .cmd              (cmd),
    .stat             (stat),
    .rsp              (rsp)
  );

`ifndef NO_ASSERTIONS
  a_evict_addr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.evicted_valid |-> rsp.evicted_address == 64'd0)
    else $error("evicted address set without an eviction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.hit |-> !rsp.evicted_valid)
    else $error("hit reported an eviction");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> {1'b0, rsp.slot} < 9'(ENTRIES))
    else $error("slot outside the ring");

  a_publish_once: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> !cmd.publish)
    else $error("two results published for one transaction");
`endif

endmodule

// ===== design/bctd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bctd_ctrl
// Sequencer: steps one transaction through divide, match, update and publish, or through cancel and publish.
// ----------------------------------------------------------------------------
module bctd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bctd_pkg::dp_status_t stat,
  output bctd_pkg::dp_cmd_t    cmd
);

  bctd_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bctd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      bctd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = bctd_pkg::ST_DIV;
        end
      end
      bctd_pkg::ST_DIV: begin
        // A cancel skips the remainder and the match entirely.
        if (stat.is_cancel) begin
          state_next = bctd_pkg::ST_CANCEL;
        end else begin
          cmd.div_step = 1'b1;
          if (stat.div_last) begin
            state_next = bctd_pkg::ST_ALIGN;
          end
        end
      end
      bctd_pkg::ST_ALIGN: begin
        cmd.align  = 1'b1;
        state_next = bctd_pkg::ST_CMP;
      end
      bctd_pkg::ST_CMP: begin
        cmd.compare = 1'b1;
        state_next  = bctd_pkg::ST_ENC;
      end
      bctd_pkg::ST_ENC: begin
        cmd.encode = 1'b1;
        state_next = bctd_pkg::ST_READ;
      end
      bctd_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = bctd_pkg::ST_WRITE;
      end
      bctd_pkg::ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = stat.swap_needed ? bctd_pkg::ST_SWAP : bctd_pkg::ST_DONE;
      end
      bctd_pkg::ST_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = bctd_pkg::ST_DONE;
      end
      bctd_pkg::ST_CANCEL: begin
        cmd.cancel = 1'b1;
        state_next = bctd_pkg::ST_DONE;
      end
      bctd_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = bctd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bctd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/bctd_datapath.sv =====
// ----------------------------------------------------------------------------
// bctd_datapath
// Remainder unit, slot directory, ring pointer and result register.
// ----------------------------------------------------------------------------
module bctd_datapath #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [16:0]           cfg_data,
  input  logic                  req_mode,
  input  logic [63:0]           req_byte_address,
  input  bctd_pkg::dp_cmd_t     cmd,
  output bctd_pkg::dp_status_t  stat,
  bctd_rsp_if.source            rsp
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [bctd_pkg::BSIZE_W-1:0]   block_size;
  logic [bctd_pkg::ADDR_W-1:0]    slot_tag [ENTRIES];
  logic [ENTRIES-1:0]             slot_mapped;
  logic [IDX_W-1:0]               top_slot;
  logic                           last_was_miss;

  logic                           mode_r;
  logic [bctd_pkg::ADDR_W-1:0]    addr_r;
  logic [bctd_pkg::ADDR_W-1:0]    quot_sh;
  logic [bctd_pkg::BSIZE_W-1:0]   rem;
  logic [bctd_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [bctd_pkg::ADDR_W-1:0]    baddr;
  logic [ENTRIES-1:0]             match;
  logic                           hit_r;
  logic [IDX_W-1:0]               found;
  logic [IDX_W-1:0]               nb_idx;
  logic [bctd_pkg::ADDR_W-1:0]    temp_tag;
  logic                           temp_mapped;
  logic [IDX_W-1:0]               res_slot;
  logic                           res_evv;
  logic [bctd_pkg::ADDR_W-1:0]    res_eva;

  logic [bctd_pkg::BSIZE_W:0]     rem_sh;
  logic [bctd_pkg::BSIZE_W:0]     rem_sub;
  logic [IDX_W-1:0]               found_next;
  logic [IDX_W-1:0]               rd_base;
  logic [IDX_W-1:0]               rd_idx;
  logic [IDX_W-1:0]               top_inc;
  logic                           cfg_take;

  // Restoring remainder, one address bit per cycle from the top.
  assign rem_sh  = {rem, quot_sh[bctd_pkg::ADDR_W-1]};
  assign rem_sub = rem_sh - {1'b0, block_size};

  always_comb begin
    found_next = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_next = IDX_W'(i);
      end
    end
  end

  assign rd_base  = hit_r ? found : top_slot;
  assign rd_idx   = (rd_base == '0) ? LAST_IDX : rd_base - 1'b1;
  assign top_inc  = (top_slot == LAST_IDX) ? '0 : top_slot + 1'b1;
  assign cfg_take = cfg_we && (cfg_data >= bctd_pkg::BSIZE_MIN) && (cfg_data != block_size);

  assign stat.is_cancel   = (mode_r == bctd_pkg::MODE_CANCEL);
  assign stat.div_last    = (div_cnt == '1);
  assign stat.swap_needed = hit_r && (found != top_slot);
  assign stat.out_busy    = rsp.valid && !rsp.ready;

  // Control state of the directory.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= bctd_pkg::BSIZE_RESET;
      slot_mapped   <= '0;
      top_slot      <= '0;
      last_was_miss <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg_take) begin
        block_size    <= cfg_data;
        slot_mapped   <= '0;
        top_slot      <= '0;
        last_was_miss <= 1'b0;
      end
      if (cmd.write) begin
        if (hit_r) begin
          last_was_miss <= 1'b0;
          if (found != top_slot) begin
            slot_mapped[nb_idx] <= 1'b1;
          end
        end else begin
          top_slot            <= nb_idx;
          slot_mapped[nb_idx] <= 1'b1;
          last_was_miss       <= 1'b1;
        end
      end
      if (cmd.swap) begin
        slot_mapped[found] <= temp_mapped;
      end
      if (cmd.cancel && last_was_miss) begin
        slot_mapped[top_slot] <= 1'b0;
        top_slot              <= top_inc;
        last_was_miss         <= 1'b0;
      end
      if (cmd.publish) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= req_mode;
      addr_r  <= req_byte_address;
      quot_sh <= req_byte_address;
      rem     <= '0;
      div_cnt <= '0;
      baddr   <= '0;
      res_evv <= 1'b0;
      res_eva <= '0;
      hit_r   <= 1'b0;
    end
    if (cmd.div_step) begin
      quot_sh <= {quot_sh[bctd_pkg::ADDR_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
      rem     <= rem_sub[bctd_pkg::BSIZE_W] ? rem_sh[bctd_pkg::BSIZE_W-1:0]
                                             : rem_sub[bctd_pkg::BSIZE_W-1:0];
    end
    if (cmd.align) begin
      baddr <= addr_r - {{(bctd_pkg::ADDR_W-bctd_pkg::BSIZE_W){1'b0}}, rem};
    end
    if (cmd.compare) begin
      for (int i = 0; i < ENTRIES; i++) begin
        match[i] <= slot_mapped[i] && (slot_tag[i] == baddr);
      end
    end
    if (cmd.encode) begin
      found <= found_next;
      hit_r <= |match;
    end
    if (cmd.read) begin
      nb_idx      <= rd_idx;
      temp_tag    <= slot_tag[rd_idx];
      temp_mapped <= slot_mapped[rd_idx];
    end
    if (cmd.write) begin
      if (hit_r) begin
        if (found != top_slot) begin
          slot_tag[nb_idx] <= baddr;
          res_slot         <= nb_idx;
        end else begin
          res_slot <= found;
        end
      end else begin
        slot_tag[nb_idx] <= baddr;
        res_slot         <= nb_idx;
        res_evv          <= temp_mapped;
        res_eva          <= temp_mapped ? temp_tag : '0;
      end
    end
    if (cmd.swap) begin
      slot_tag[found] <= temp_tag;
    end
    if (cmd.publish) begin
      rsp.hit             <= hit_r;
      rsp.slot            <= stat.is_cancel ? bctd_pkg::SLOT_W'(top_slot)
                                            : bctd_pkg::SLOT_W'(res_slot);
      rsp.block_address   <= baddr;
      rsp.evicted_valid   <= res_evv;
      rsp.evicted_address <= res_eva;
    end
  end

endmodule
